>>> design/hah_pkg.sv
// Shared types and constants for the hourly average history block.
// No dependencies; every design file but hah_fifo imports this package.
`default_nettype none

package hah_pkg;

  localparam int HOUR_W  = 5;
  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_DUMP = 1'b1
  } op_e;

  typedef enum logic {
    CMD_CLOSE = 1'b0,
    CMD_DUMP  = 1'b1
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DUMP_RD,
    BK_DUMP_LD
  } back_state_e;

endpackage

`default_nettype wire

>>> design/hah_fifo.sv
// Small command queue between the front and back of the history block.
// Depends on nothing; data is shown first-word-fall-through.
`default_nettype none

module hah_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> design/hah_front.sv
// Front end: accepts items, reduces the hour, keeps the open-hour sum and count.
// Depends on hah_pkg; pushes close and dump commands into the queue.
`default_nettype none

module hah_front
  import hah_pkg::*;
#(
  parameter int SLOTS        = 24,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    opcode_i,
  input  wire logic [HOUR_W-1:0]       hour_now_i,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                         push_o,
  // kind, slot, count and sum, high bit down
  output logic [$clog2(SLOTS)+2*COUNT_W+SAMPLE_WIDTH:0] push_data_o,
  input  wire logic                    full_i
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SUM_W  = SAMPLE_WIDTH + COUNT_W;
  localparam int HOURS  = 2 ** HOUR_W;

  logic [SLOT_W-1:0] hour_tbl [HOURS];

  // hour modulo SLOTS, worked out at elaboration
  for (genvar g = 0; g < HOURS; g++) begin : g_hour_tbl
    localparam int REDUCED = g % SLOTS;
    assign hour_tbl[g] = SLOT_W'(REDUCED);
  end

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [COUNT_W-1:0]      count_q, count_d;
  logic [SLOT_W-1:0]       open_q, open_d;
  logic [SLOT_W-1:0]       hour;
  logic signed [SUM_W-1:0] sample_ext;
  logic                    accept;
  cmd_kind_e               kind;
  logic [SLOT_W-1:0]       cmd_slot;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hour       = hour_tbl[hour_now_i];
  assign sample_ext = {{COUNT_W{sample_i[SAMPLE_WIDTH-1]}}, sample_i};

  always_comb begin
    sum_d    = sum_q;
    count_d  = count_q;
    open_d   = open_q;
    push_o   = 1'b0;
    kind     = CMD_CLOSE;
    cmd_slot = open_q;
    if (accept) begin
      if (op_e'(opcode_i) == OP_DUMP) begin
        push_o   = 1'b1;
        kind     = CMD_DUMP;
        cmd_slot = hour;
      end else if (hour == open_q) begin
        if (count_q < COUNT_MAX) begin
          sum_d   = sum_q + sample_ext;
          count_d = count_q + 1'b1;
        end
      end else begin
        // close the finished hour and open a new one with this sample
        push_o  = 1'b1;
        open_d  = hour;
        count_d = COUNT_W'(1);
        sum_d   = sample_ext;
      end
    end
  end

  assign push_data_o = {kind, cmd_slot, count_q, sum_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      open_q  <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      open_q  <= open_d;
    end
  end

endmodule

`default_nettype wire

>>> design/hah_div.sv
// Iterative signed divider: one quotient bit per cycle, truncation toward zero.
// Depends on hah_pkg for the divisor width.
`default_nettype none

module hah_div
  import hah_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic signed [SAMPLE_WIDTH+COUNT_W-1:0] dividend_i,
  input  wire logic [COUNT_W-1:0]                     divisor_i,
  output logic                                        done_o,
  output logic [SAMPLE_WIDTH-1:0]                     quotient_o
);

  localparam int SUM_W  = SAMPLE_WIDTH + COUNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     step_q;
  logic [COUNT_W-1:0]    rem_q, rem_d;
  logic [SUM_W-1:0]      quo_q, quo_d;
  logic [COUNT_W-1:0]    div_q;
  logic                  neg_q;
  logic [SAMPLE_WIDTH-1:0] res_q;
  logic [COUNT_W:0]      trial, diff;
  logic                  fits;
  logic [SUM_W-1:0]      signed_quo;

  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    diff  = trial - {1'b0, div_q};
    fits  = (trial >= {1'b0, div_q});
    rem_d = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
    quo_d = {quo_q[SUM_W-2:0], fits};
    signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : dividend_i;
      neg_q <= dividend_i[SUM_W-1];
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      if (step_q == '0) begin
        res_q <= signed_quo[SAMPLE_WIDTH-1:0];
      end else begin
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = res_q;

endmodule

`default_nettype wire

>>> design/hah_back.sv
// Back end: runs queued commands, writes hourly means, streams dumps.
// Depends on hah_pkg; drives the divider and owns the history memory.
`default_nettype none

module hah_back
  import hah_pkg::*;
#(
  parameter int SLOTS        = 24,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // kind, slot, count and sum, high bit down
  input  wire logic [$clog2(SLOTS)+2*COUNT_W+SAMPLE_WIDTH:0] cmd_i,
  input  wire logic                    empty_i,
  output logic                         pop_o,
  output logic                         div_start_o,
  output logic signed [SAMPLE_WIDTH+COUNT_W-1:0] div_dividend_o,
  output logic [COUNT_W-1:0]           div_divisor_o,
  input  wire logic                    div_done_i,
  input  wire logic [SAMPLE_WIDTH-1:0] div_quot_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]      out_average_o,
  output logic [HOUR_W-1:0]            out_slot_hour_o,
  output logic                         out_last_o
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SUM_W  = SAMPLE_WIDTH + COUNT_W;
  localparam int CMD_W  = 1 + SLOT_W + COUNT_W + SUM_W;

  back_state_e state_q, state_d;

  cmd_kind_e         cmd_kind;
  logic [SLOT_W-1:0] cmd_slot;
  logic [COUNT_W-1:0] cmd_count;

  logic [SAMPLE_WIDTH-1:0] mem_q [SLOTS];
  logic [SLOTS-1:0]        valid_q;
  logic [SAMPLE_WIDTH-1:0] rdata_q;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_waddr;
  logic [SAMPLE_WIDTH-1:0] mem_wdata;

  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] addr_q;
  logic [SLOT_W-1:0] cnt_q;
  logic              is_last;
  logic              load_out;

  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_avg_q;
  logic [HOUR_W-1:0]       out_hour_q;
  logic                    out_last_q;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  assign cmd_kind       = cmd_kind_e'(cmd_i[CMD_W-1]);
  assign cmd_slot       = cmd_i[CMD_W-2 -: SLOT_W];
  assign cmd_count      = cmd_i[SUM_W +: COUNT_W];
  assign div_dividend_o = cmd_i[SUM_W-1:0];
  assign div_divisor_o  = cmd_count;
  assign is_last        = (cnt_q == SLOT_W'(SLOTS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          if (cmd_kind == CMD_DUMP) begin
            state_d = BK_DUMP_RD;
          end else if (cmd_count != '0) begin
            state_d = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        if (div_done_i) begin
          state_d = BK_IDLE;
        end
      end
      BK_DUMP_RD: begin
        state_d = BK_DUMP_LD;
      end
      BK_DUMP_LD: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = is_last ? BK_IDLE : BK_DUMP_RD;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    pop_o       = 1'b0;
    div_start_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cmd_slot;
    mem_wdata   = '0;
    load_out    = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_kind == CMD_CLOSE) begin
            if (cmd_count == '0) begin
              mem_we = 1'b1;
            end else begin
              div_start_o = 1'b1;
            end
          end
        end
      end
      BK_DIV: begin
        mem_waddr = slot_q;
        mem_wdata = div_quot_i;
        mem_we    = div_done_i;
      end
      BK_DUMP_RD: begin
      end
      BK_DUMP_LD: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
      end
      if (pop_o && cmd_kind == CMD_DUMP) begin
        cnt_q <= '0;
      end else if (load_out) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start_o) begin
      slot_q <= cmd_slot;
    end
    if (pop_o && cmd_kind == CMD_DUMP) begin
      addr_q <= slot_inc(cmd_slot);
    end else if (load_out) begin
      addr_q <= slot_inc(addr_q);
    end
    if (load_out) begin
      out_avg_q  <= valid_q[addr_q] ? rdata_q : '0;
      out_hour_q <= HOUR_W'(addr_q);
      out_last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[addr_q];
  end

  assign out_valid_o     = out_valid_q;
  assign out_average_o   = out_avg_q;
  assign out_slot_hour_o = out_hour_q;
  assign out_last_o      = out_last_q;

endmodule

`default_nettype wire

>>> design/hourly_average_history.sv
// Hourly average history: binned running mean with a per-hour history store.
// Top level; depends on hah_pkg, hah_front, hah_fifo, hah_div and hah_back.
//
// Usage:
//   Slave stream carries commands. tuser selects the operation (add sample
//   or dump), tdata holds the hour of day and the signed sample. An add
//   never produces output; when its hour differs from the open hour, the
//   finished hour's truncated mean is written to that hour's slot.
//   A dump streams SLOTS items on the master stream, oldest first starting
//   at slot (hour+1) mod SLOTS, with tlast on the final item.
// Timing:
//   Commands cross a 4-deep queue; the input stalls only when it is full.
//   Closing an hour holds the back end until the one-bit-per-cycle divider
//   is done. A dump costs, for each slot, one registered memory read and
//   one output register load.
// Reset:
//   Clears the running sum, count, open hour and the per-slot valid bits, so
//   every slot reads as zero until written; no clearing pass is needed.
// Stalls:
//   A stalled receiver holds the output register; the dump pauses and the
//   front keeps taking adds until the queue fills.
`default_nettype none

module hourly_average_history
  import hah_pkg::*;
#(
  parameter int SLOTS        = 24,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // slave stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata, low bit up: hour_now[4:0], sample[SAMPLE_WIDTH-1:0], zero fill
  input  wire logic [((HOUR_W + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser, low bit up: opcode
  input  wire logic [0:0]        s_axis_tuser,
  // master stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // tdata, low bit up: average[SAMPLE_WIDTH-1:0], slot_hour[4:0], zero fill
  output logic [((SAMPLE_WIDTH + HOUR_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int OUT_W       = ((SAMPLE_WIDTH + HOUR_W + 7) / 8) * 8;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int SUM_W       = SAMPLE_WIDTH + COUNT_W;
  localparam int CMD_W       = 1 + SLOT_W + COUNT_W + SUM_W;
  localparam int QUEUE_DEPTH = 4;

  // command queue between front and back
  logic             q_push, q_pop, q_full, q_empty;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  // divider handshake
  logic                    div_start, div_done;
  logic signed [SUM_W-1:0] div_dividend;
  logic [COUNT_W-1:0]      div_divisor;
  logic [SAMPLE_WIDTH-1:0] div_quot;

  // result fields
  logic [SAMPLE_WIDTH-1:0] out_average;
  logic [HOUR_W-1:0]       out_slot_hour;

  hah_front #(
    .SLOTS        (SLOTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser[0]),
    .hour_now_i  (s_axis_tdata[HOUR_W-1:0]),
    .sample_i    (s_axis_tdata[HOUR_W +: SAMPLE_WIDTH]),
    .push_o      (q_push),
    .push_data_o (q_wdata),
    .full_i      (q_full)
  );

  hah_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  hah_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  hah_back #(
    .SLOTS        (SLOTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (q_rdata),
    .empty_i         (q_empty),
    .pop_o           (q_pop),
    .div_start_o     (div_start),
    .div_dividend_o  (div_dividend),
    .div_divisor_o   (div_divisor),
    .div_done_i      (div_done),
    .div_quot_i      (div_quot),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_average_o   (out_average),
    .out_slot_hour_o (out_slot_hour),
    .out_last_o      (m_axis_tlast)
  );

  // pack result fields, zero fill to whole bytes
  assign m_axis_tdata = OUT_W'({out_slot_hour, out_average});

  // front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // a division holds the back end; no second start right after one
  a_div_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_start && !q_pop)
    else $error("back end moved on during a division");

  // a division result is never ready in the cycle after its start
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_done)
    else $error("divider finished too early");

endmodule

`default_nettype wire
